>>> rtl/blocked_bloom_filter_macros.svh
// ----------------------------------------------------------------------------
// Blocked Bloom filter assertion macros
// Concurrent assertion wrappers; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef BLOCKED_BLOOM_FILTER_MACROS_SVH
`define BLOCKED_BLOOM_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off while rst_n is low
`define BBF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbf assertion failed");
// next-cycle implication
`define BBF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbf assertion failed");
`else
`define BBF_ASSERT_NOW(label, ante, cons)
`define BBF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/bbf_pkg.sv
// ----------------------------------------------------------------------------
// Blocked Bloom filter package
// Sizes, command and job codes, hash constants and helper functions.
// ----------------------------------------------------------------------------
package bbf_pkg;

    localparam int MAX_BLOCKS      = 64;
    localparam int BLOCK_BITS      = 1024;
    localparam int HASH_COUNT      = 3;
    localparam int WORD_W          = 64;
    localparam int WORDS_PER_BLOCK = BLOCK_BITS / WORD_W;
    localparam int TOTAL_WORDS     = MAX_BLOCKS * WORDS_PER_BLOCK;
    localparam int ADDR_W          = $clog2(TOTAL_WORDS);
    localparam int BLK_W           = $clog2(MAX_BLOCKS);
    localparam int POS_W           = $clog2(BLOCK_BITS);
    localparam int BIT_W           = $clog2(WORD_W);
    localparam int CNT_W           = 7;
    localparam int HIDX_W          = $clog2(HASH_COUNT + 1);
    localparam int KEY_W           = 64;
    localparam int DIV_STEP        = 4;
    localparam int DIV_CYCLES      = KEY_W / DIV_STEP;
    localparam int DIV_CNT_W       = $clog2(DIV_CYCLES);

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_QUERY  = 2'd1;
    localparam cmd_t CMD_CLEAR  = 2'd2;

    localparam logic REG_HASH_SEED   = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    typedef logic [2:0] kind_t;
    localparam kind_t K_INSERT = 3'd0;
    localparam kind_t K_QUERY  = 3'd1;
    localparam kind_t K_CLEAR  = 3'd2;
    localparam kind_t K_DONE   = 3'd3;
    localparam kind_t K_REJECT = 3'd4;

    typedef struct packed {
        kind_t                               kind;
        logic [BLK_W-1:0]                    blk;
        logic [HASH_COUNT-1:0][POS_W-1:0]    pos;
    } bbf_job_t;

    localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;
    localparam logic [63:0] XXH_BIAS = PR5 + 64'd8;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    // seed offset of hash j: block hash uses the seed, bit hash i uses seed + i + 2
    function automatic logic [63:0] seed_offset(input logic [HIDX_W-1:0] j);
        logic [63:0] off;
        off = (j == '0) ? 64'd0 : (64'(j) + 64'd1);
        return off;
    endfunction

    // first multiplier operand of a hash round, from seed sum and shared lane term
    function automatic logic [63:0] hash_lane0(input logic [63:0] seed_sum,
                                               input logic [63:0] k);
        return rotl64(seed_sum ^ k, 27);
    endfunction

endpackage

>>> rtl/bbf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write when we is high, registered read data.
// ----------------------------------------------------------------------------
module bbf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/bbf_front.sv
// ----------------------------------------------------------------------------
// Blocked Bloom filter front end
// Classifies commands, runs the four XXH64 hashes on one shared 32x32
// multiplier and reduces the block hash modulo the block count.
// ----------------------------------------------------------------------------
module bbf_front
    import bbf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  cmd_t             cmd,
    input  logic [KEY_W-1:0] key,
    input  logic [63:0]      hash_seed,
    input  logic [CNT_W-1:0] block_count,
    input  logic             q_full,
    output logic             front_busy,
    output logic             push,
    output bbf_job_t         push_job
);

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_MUL  = 2'd1;
    localparam logic [1:0] FS_DIV  = 2'd2;
    localparam logic [1:0] FS_PUSH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [1:0]          sub_reg, sub_next;
    logic [HIDX_W-1:0]   hidx_reg, hidx_next;
    logic                kdone_reg, kdone_next;
    logic [63:0]         mul_a_reg, mul_a_next;
    logic [63:0]         mul_b_reg, mul_b_next;
    logic [63:0]         acc_reg, acc_next;
    logic [63:0]         k_reg, k_next;
    logic [63:0]         bhash_reg, bhash_next;
    logic [CNT_W-1:0]    nblk_reg, nblk_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    bbf_job_t            job_reg, job_next;

    logic [31:0]         mx, my;
    logic [63:0]         product;
    logic [63:0]         t, hv;
    logic [CNT_W-1:0]    nblk_in, r;
    logic [63:0]         q;
    logic [HIDX_W-1:0]   hnext;

    assign mx      = (phase_reg == 2'd1) ? mul_a_reg[63:32] : mul_a_reg[31:0];
    assign my      = (phase_reg == 2'd2) ? mul_b_reg[63:32] : mul_b_reg[31:0];
    assign product = 64'(mx) * 64'(my);
    assign nblk_in = (block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : block_count;
    assign hnext   = hidx_reg + HIDX_W'(1);

    assign front_busy = (state_reg != FS_IDLE);
    assign push       = (state_reg == FS_PUSH) && !q_full;
    assign push_job   = job_reg;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        sub_next   = sub_reg;
        hidx_next  = hidx_reg;
        kdone_next = kdone_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        acc_next   = acc_reg;
        k_next     = k_reg;
        bhash_next = bhash_reg;
        nblk_next  = nblk_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        job_next   = job_reg;
        t          = acc_reg + PR4;
        hv         = acc_reg ^ (acc_reg >> 32);
        r          = rem_reg;
        q          = bhash_reg;

        case (state_reg)
            FS_IDLE:
            begin
                if (accept)
                begin
                    nblk_next  = nblk_in;
                    mul_a_next = key;
                    mul_b_next = PR2;
                    phase_next = 2'd0;
                    sub_next   = 2'd0;
                    hidx_next  = '0;
                    kdone_next = 1'b0;
                    state_next = FS_PUSH;
                    if (cmd == CMD_CLEAR)
                    begin
                        job_next.kind = K_CLEAR;
                    end
                    else if (cmd == CMD_INSERT || cmd == CMD_QUERY)
                    begin
                        if (nblk_in == '0)
                        begin
                            job_next.kind = (cmd == CMD_INSERT) ? K_REJECT : K_DONE;
                        end
                        else
                        begin
                            job_next.kind = (cmd == CMD_INSERT) ? K_INSERT : K_QUERY;
                            state_next    = FS_MUL;
                        end
                    end
                    else
                    begin
                        job_next.kind = K_DONE;
                    end
                end
            end

            FS_MUL:
            begin
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    2'd0:    acc_next = product;
                    2'd1,
                    2'd2:    acc_next = acc_reg + {product[31:0], 32'd0};
                    default:
                    begin
                        if (!kdone_reg)
                        begin
                            if (sub_reg == 2'd0)
                            begin
                                mul_a_next = rotl64(acc_reg, 31);
                                mul_b_next = PR1;
                                sub_next   = 2'd1;
                            end
                            else
                            begin
                                k_next     = acc_reg;
                                mul_a_next = hash_lane0(hash_seed + XXH_BIAS, acc_reg);
                                mul_b_next = PR1;
                                kdone_next = 1'b1;
                                sub_next   = 2'd0;
                            end
                        end
                        else
                        begin
                            case (sub_reg)
                                2'd0:
                                begin
                                    mul_a_next = t ^ (t >> 33);
                                    mul_b_next = PR2;
                                    sub_next   = 2'd1;
                                end
                                2'd1:
                                begin
                                    mul_a_next = acc_reg ^ (acc_reg >> 29);
                                    mul_b_next = PR3;
                                    sub_next   = 2'd2;
                                end
                                default:
                                begin
                                    // round finished: keep the hash, start the next seed
                                    if (hidx_reg == '0)
                                    begin
                                        bhash_next = hv;
                                    end
                                    else
                                    begin
                                        job_next.pos[hidx_reg - HIDX_W'(1)] = hv[POS_W-1:0];
                                    end
                                    sub_next   = 2'd0;
                                    hidx_next  = hnext;
                                    mul_a_next = hash_lane0(hash_seed + XXH_BIAS
                                                            + seed_offset(hnext), k_reg);
                                    mul_b_next = PR1;
                                    if (hidx_reg == HIDX_W'(HASH_COUNT))
                                    begin
                                        rem_next   = '0;
                                        dcnt_next  = '0;
                                        state_next = FS_DIV;
                                    end
                                end
                            endcase
                        end
                    end
                endcase
            end

            FS_DIV:
            begin
                // restoring remainder, DIV_STEP dividend bits per cycle
                for (int i = 0; i < DIV_STEP; i++)
                begin
                    r = {r[CNT_W-2:0], q[63]};
                    q = {q[62:0], 1'b0};
                    if (r >= nblk_reg)
                    begin
                        r = r - nblk_reg;
                    end
                end
                rem_next   = r;
                bhash_next = q;
                dcnt_next  = dcnt_reg + DIV_CNT_W'(1);
                if (dcnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    job_next.blk = r[BLK_W-1:0];
                    state_next   = FS_PUSH;
                end
            end

            default:
            begin
                if (!q_full)
                begin
                    state_next = FS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        sub_reg   <= sub_next;
        hidx_reg  <= hidx_next;
        kdone_reg <= kdone_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        acc_reg   <= acc_next;
        k_reg     <= k_next;
        bhash_reg <= bhash_next;
        nblk_reg  <= nblk_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        job_reg   <= job_next;
    end

endmodule

>>> rtl/bbf_queue.sv
// ----------------------------------------------------------------------------
// Blocked Bloom filter job queue
// Two-entry FIFO between the hash front end and the memory back end.
// ----------------------------------------------------------------------------
module bbf_queue
    import bbf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bbf_job_t push_job,
    input  logic     pop,
    output bbf_job_t head,
    output logic     full,
    output logic     empty
);

    bbf_job_t   slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/bbf_exec.sv
// ----------------------------------------------------------------------------
// Blocked Bloom filter back end
// Owns the filter memory: clearing sweeps, per-bit reads and per-bit read-modify-writes.
// ----------------------------------------------------------------------------
`include "blocked_bloom_filter_macros.svh"

module bbf_exec
    import bbf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     empty,
    input  bbf_job_t head,
    output logic     pop,
    output logic     init_busy,
    output logic     done,
    output logic     maybe_present,
    output logic     status
);

    localparam logic [2:0] BS_INIT = 3'd0;
    localparam logic [2:0] BS_IDLE = 3'd1;
    localparam logic [2:0] BS_CLR  = 3'd2;
    localparam logic [2:0] BS_RD   = 3'd3;
    localparam logic [2:0] BS_MOD  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [1:0]        idx_reg, idx_next;
    logic              all_reg, all_next;
    logic              done_reg, done_next;
    logic              present_reg, present_next;
    logic              status_reg, status_next;
    bbf_job_t          work_reg, work_next;

    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [POS_W-1:0]  cur_pos;
    logic              hit;

    bbf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TOTAL_WORDS)
    ) u_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign cur_pos       = work_reg.pos[idx_reg];
    assign hit           = ram_rdata[cur_pos[BIT_W-1:0]];
    assign init_busy     = (state_reg == BS_INIT);
    assign done          = done_reg;
    assign maybe_present = present_reg;
    assign status        = status_reg;

    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        idx_next     = idx_reg;
        all_next     = all_reg;
        work_next    = work_reg;
        done_next    = 1'b0;
        present_next = 1'b0;
        status_next  = 1'b0;
        pop          = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = {work_reg.blk, cur_pos[POS_W-1:BIT_W]};
        ram_wdata    = ram_rdata | (WORD_W'(1) << cur_pos[BIT_W-1:0]);

        case (state_reg)
            BS_INIT,
            BS_CLR:
            begin
                ram_addr  = addr_reg;
                ram_we    = 1'b1;
                ram_wdata = '0;
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(TOTAL_WORDS - 1))
                begin
                    done_next  = (state_reg == BS_CLR);
                    state_next = BS_IDLE;
                end
            end

            BS_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    work_next = head;
                    addr_next = '0;
                    idx_next  = 2'd0;
                    all_next  = 1'b1;
                    case (head.kind)
                        K_CLEAR:  state_next = BS_CLR;
                        K_INSERT,
                        K_QUERY:  state_next = BS_RD;
                        K_REJECT:
                        begin
                            done_next   = 1'b1;
                            status_next = 1'b1;
                        end
                        default:  done_next = 1'b1;
                    endcase
                end
            end

            BS_RD:
            begin
                state_next = BS_MOD;
            end

            BS_MOD:
            begin
                ram_we   = (work_reg.kind == K_INSERT);
                all_next = all_reg & hit;
                if (idx_reg == 2'(HASH_COUNT - 1))
                begin
                    done_next    = 1'b1;
                    present_next = (work_reg.kind == K_QUERY) && all_reg && hit;
                    state_next   = BS_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = BS_RD;
                end
            end

            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_INIT;
            addr_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        all_reg     <= all_next;
        present_reg <= present_next;
        status_reg  <= status_next;
        work_reg    <= work_next;
    end

    `BBF_ASSERT_NOW(a_present_only_query, done_reg && present_reg, work_reg.kind == K_QUERY)
    `BBF_ASSERT_NOW(a_status_only_reject, done_reg && status_reg, work_reg.kind == K_REJECT)
    `BBF_ASSERT_NOW(a_write_own_block, ram_we && state_reg == BS_MOD, ram_addr[ADDR_W-1:ADDR_W-BLK_W] == work_reg.blk)
    `BBF_ASSERT_NEXT(a_pop_leaves_idle, pop && (head.kind == K_INSERT || head.kind == K_QUERY), state_reg == BS_RD)

endmodule

>>> rtl/blocked_bloom_filter.sv
// ----------------------------------------------------------------------------
// Blocked Bloom filter
// XXH64-hashed blocked Bloom filter over 64 blocks of 1024 bits, with
// insert, query and clear commands and two configuration registers.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// command   in         start & !busy          cmd, key
// result    out        done (one-cycle pulse) maybe_present, status
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// Insert and query run four XXH64 rounds in the front end, each of three
// 64-bit multiplies (plus the shared lane term) on one 32x32 multiplier,
// each multiply built from 32x32 partial products, then a radix-16 remainder.
// The back end pops each job, then per bit reads the memory word and, for
// an insert, writes it back with the bit set.
// Clear sweeps all 1024 memory words, one per cycle, before its result.
// After reset the same sweep runs and busy stays high until it ends.
// The receiver cannot stall; a two-entry job queue lets the front end keep
// hashing while the back end sweeps or updates.
//
module blocked_bloom_filter
    import bbf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // command transaction
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       cmd,
    input  logic [KEY_W-1:0] key,
    // result transaction
    output logic             done,
    output logic             maybe_present,
    output logic             status,
    // configuration write transaction
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [63:0]      cfg_data
);

    logic [63:0]      hash_seed_reg;
    logic [CNT_W-1:0] block_count_reg;
    logic             accept;
    logic             front_busy, init_busy;
    logic             push, pop, q_full, q_empty;
    bbf_job_t         push_job, head;

    // hold off commands while hashing or during the power-up sweep
    assign busy      = front_busy | init_busy;
    assign accept    = start & ~busy;
    assign cfg_ready = 1'b1;

    // configuration registers; user writes them only while idle, unenforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg   <= '0;
            block_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HASH_SEED:   hash_seed_reg   <= cfg_data;
                REG_BLOCK_COUNT: block_count_reg <= cfg_data[CNT_W-1:0];
                default:         hash_seed_reg   <= hash_seed_reg;
            endcase
        end
    end

    // classify and hash
    bbf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd),
        .key         (key),
        .hash_seed   (hash_seed_reg),
        .block_count (block_count_reg),
        .q_full      (q_full),
        .front_busy  (front_busy),
        .push        (push),
        .push_job    (push_job)
    );

    // decouple hashing from memory work
    bbf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // advance jobs through the filter memory and drive results
    bbf_exec u_exec (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (q_empty),
        .head          (head),
        .pop           (pop),
        .init_busy     (init_busy),
        .done          (done),
        .maybe_present (maybe_present),
        .status        (status)
    );

endmodule
